// ===== src/rrps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrps_pkg
// Shared constants of the rounded rectangle pixel shader: register map,
// register reset values and the coverage scale.
// ----------------------------------------------------------------------------
package rrps_pkg;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] CFG_RECT_WIDTH    = 3'd0;
  localparam logic [2:0] CFG_RECT_HEIGHT   = 3'd1;
  localparam logic [2:0] CFG_CORNER_RADIUS = 3'd2;
  localparam logic [2:0] CFG_FILL_COLOR    = 3'd3;
  localparam logic [2:0] CFG_BORDER_COLOR  = 3'd4;

  // register reset values
  localparam logic [10:0] RST_RECT_WIDTH    = 11'd64;
  localparam logic [10:0] RST_RECT_HEIGHT   = 11'd32;
  localparam logic [9:0]  RST_CORNER_RADIUS = 10'd8;
  localparam logic [31:0] RST_FILL_COLOR    = 32'h0000_0000;
  localparam logic [31:0] RST_BORDER_COLOR  = 32'h0000_0000;

  // coverage of one, in 8 fractional bits
  localparam logic [8:0] COV_ONE = 9'd256;

endpackage

// ===== src/rrps_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrps_in_if
// Pixel coordinate channel: valid, ready and one supersampled coordinate.
// ----------------------------------------------------------------------------
interface rrps_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== src/rrps_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrps_out_if
// Pixel color channel: valid, ready and one RGBA color.
// ----------------------------------------------------------------------------
interface rrps_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, output red, output green, output blue,
                  output alpha, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input alpha, output ready);
endinterface

// ===== src/rounded_rect_pixel_shader_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_rect_pixel_shader_unit
// Antialiased rounded rectangle shader: one supersampled pixel coordinate
// in, one RGBA color out.
// ----------------------------------------------------------------------------
// Usage:
//   in_pix carries pixel_x / pixel_y beats, out_pix carries red, green,
//   blue and alpha beats, both valid/ready. Geometry and colors are set
//   through the APB-style cfg_ port at byte addresses 0, 4, 8, 12, 16
//   (width, height, radius, fill color, border color). The user must
//   set them only while no pixel is in flight; the block does not enforce
//   it. pready is always high and reads return the register. Throughput
//   is one pixel per clock while out_pix does not stall. There are four
//   front stages, one cell per root bit in the square root chain, and
//   three back stages. Every stage holds its own beat, so when out_pix
//   stalls the pipeline keeps filling empty stages and in_pix stays ready
//   until all are full. Reset empties the pipeline and loads the register
//   reset values.
// ----------------------------------------------------------------------------
module rounded_rect_pixel_shader_unit #(
  parameter int SUPERSAMPLE_FACTOR = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  rrps_in_if.sink     in_pix,
  rrps_out_if.source  out_pix,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rrps_pkg::*;

  localparam int S    = SUPERSAMPLE_FACTOR;
  localparam int MULW = $clog2(2047*S+1);
  localparam int LW   = MULW + 9;
  localparam int RW   = LW + 1;

  logic [10:0] rect_width_r, rect_height_r;
  logic [9:0]  corner_radius_r;
  logic [31:0] fill_color_r, border_color_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  // register write and readback
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_width_r    <= RST_RECT_WIDTH;
      rect_height_r   <= RST_RECT_HEIGHT;
      corner_radius_r <= RST_CORNER_RADIUS;
      fill_color_r    <= RST_FILL_COLOR;
      border_color_r  <= RST_BORDER_COLOR;
    end else if (wr_en) begin
      case (reg_idx)
        CFG_RECT_WIDTH:    rect_width_r    <= cfg_pwdata[10:0];
        CFG_RECT_HEIGHT:   rect_height_r   <= cfg_pwdata[10:0];
        CFG_CORNER_RADIUS: corner_radius_r <= cfg_pwdata[9:0];
        CFG_FILL_COLOR:    fill_color_r    <= cfg_pwdata;
        CFG_BORDER_COLOR:  border_color_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      CFG_RECT_WIDTH:    cfg_prdata = {21'd0, rect_width_r};
      CFG_RECT_HEIGHT:   cfg_prdata = {21'd0, rect_height_r};
      CFG_CORNER_RADIUS: cfg_prdata = {22'd0, corner_radius_r};
      CFG_FILL_COLOR:    cfg_prdata = fill_color_r;
      CFG_BORDER_COLOR:  cfg_prdata = border_color_r;
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // supersampled geometry in 8 fractional bits
  logic [MULW-1:0] w_s, h_s, r_s;
  logic signed [LW-1:0] sw8, sh8, sr8, swr, shr;

  always_comb begin
    w_s = MULW'(rect_width_r * S);
    h_s = MULW'(rect_height_r * S);
    r_s = MULW'(corner_radius_r * S);
    sw8 = {1'b0, w_s, 8'h00};
    sh8 = {1'b0, h_s, 8'h00};
    sr8 = {1'b0, r_s, 8'h00};
    swr = sw8 - sr8;
    shr = sh8 - sr8;
  end

  // front pipeline
  logic            ch_valid [RW+1];
  logic            ch_ready [RW+1];
  logic [2*RW-1:0] ch_sq    [RW+1];
  logic [RW+1:0]   ch_rem   [RW+1];
  logic [RW-1:0]   ch_root  [RW+1];

  rrps_front #(.S(S)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_pix.valid),
    .up_ready (in_pix.ready),
    .up_px    (in_pix.pixel_x),
    .up_py    (in_pix.pixel_y),
    .sr8      (sr8),
    .swr      (swr),
    .shr      (shr),
    .dn_valid (ch_valid[0]),
    .dn_ready (ch_ready[0]),
    .dn_sq    (ch_sq[0])
  );

  assign ch_rem[0]  = '0;
  assign ch_root[0] = '0;

  // square root chain, most significant root bit first
  for (genvar k = 0; k < RW; k++) begin : g_cell
    rrps_sqrt_cell #(.RW(RW), .IDX(RW - 1 - k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (ch_valid[k]),
      .up_ready (ch_ready[k]),
      .up_sq    (ch_sq[k]),
      .up_rem   (ch_rem[k]),
      .up_root  (ch_root[k]),
      .dn_valid (ch_valid[k+1]),
      .dn_ready (ch_ready[k+1]),
      .dn_sq    (ch_sq[k+1]),
      .dn_rem   (ch_rem[k+1]),
      .dn_root  (ch_root[k+1])
    );
  end

  // back pipeline
  rrps_back #(.S(S)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (ch_valid[RW]),
    .up_ready     (ch_ready[RW]),
    .up_dist      (ch_root[RW]),
    .sr8          (sr8),
    .fill_color   (fill_color_r),
    .border_color (border_color_r),
    .dn_valid     (out_pix.valid),
    .dn_ready     (out_pix.ready),
    .dn_red       (out_pix.red),
    .dn_green     (out_pix.green),
    .dn_blue      (out_pix.blue),
    .dn_alpha     (out_pix.alpha)
  );

endmodule

// ===== src/rrps_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrps_front
// Front pipeline: input register, clamp to the corner centres with absolute
// offsets, squares, and the sum of squares that feeds the root cells.
// ----------------------------------------------------------------------------
module rrps_front #(
  parameter int S = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  logic [11:0] up_px,
  input  logic [11:0] up_py,
  input  logic signed [$clog2(2047*S+1)+8:0] sr8,
  input  logic signed [$clog2(2047*S+1)+8:0] swr,
  input  logic signed [$clog2(2047*S+1)+8:0] shr,
  output logic dn_valid,
  input  logic dn_ready,
  output logic [2*($clog2(2047*S+1)+10)-1:0] dn_sq
);

  localparam int MULW = $clog2(2047*S+1);
  localparam int LW   = MULW + 9;
  localparam int DW   = LW + 1;

  logic [3:0] v_r;
  logic [4:0] rdy;

  logic [11:0] px_r, py_r;
  logic [LW-1:0] ax_r, ay_r, ax_nxt, ay_nxt;
  logic [2*LW-1:0] sqx_r, sqy_r;
  logic [2*LW:0] sum_r;

  logic signed [DW-1:0] px8, py8, sre, swre, shre, dxa, dya;

  // stage advance chain, each stage fills when empty or moving on
  always_comb begin
    rdy[4] = dn_ready;
    for (int i = 3; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[3];
  assign dn_sq    = {1'b0, sum_r};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid;
      for (int i = 1; i < 4; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // pixel centre and clamped offsets, low side tested first
  always_comb begin
    px8  = {{(DW-20){1'b0}}, px_r, 8'h80};
    py8  = {{(DW-20){1'b0}}, py_r, 8'h80};
    sre  = {sr8[LW-1], sr8};
    swre = {swr[LW-1], swr};
    shre = {shr[LW-1], shr};
    if (px8 < sre)       dxa = sre - px8;
    else if (px8 > swre) dxa = px8 - swre;
    else                 dxa = '0;
    if (py8 < sre)       dya = sre - py8;
    else if (py8 > shre) dya = py8 - shre;
    else                 dya = '0;
    ax_nxt = dxa[LW-1:0];
    ay_nxt = dya[LW-1:0];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy[0] && up_valid) begin
      px_r <= up_px;
      py_r <= up_py;
    end
    if (rdy[1] && v_r[0]) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
    end
    if (rdy[2] && v_r[1]) begin
      sqx_r <= ax_r * ax_r;
      sqy_r <= ay_r * ay_r;
    end
    if (rdy[3] && v_r[2]) begin
      sum_r <= {1'b0, sqx_r} + {1'b0, sqy_r};
    end
  end

endmodule

// ===== src/rrps_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrps_sqrt_cell
// One cell of the square root chain: takes the next two radicand bits,
// tries one root bit and hands remainder and partial root to its neighbor.
// ----------------------------------------------------------------------------
module rrps_sqrt_cell #(
  parameter int RW  = 23,
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  logic [2*RW-1:0] up_sq,
  input  logic [RW+1:0] up_rem,
  input  logic [RW-1:0] up_root,
  output logic dn_valid,
  input  logic dn_ready,
  output logic [2*RW-1:0] dn_sq,
  output logic [RW+1:0] dn_rem,
  output logic [RW-1:0] dn_root
);

  logic valid_r;
  logic [2*RW-1:0] sq_r;
  logic [RW+1:0] rem_r, rem_nxt, rem_sh, trial;
  logic [RW-1:0] root_r, root_nxt;
  logic take;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_sq    = sq_r;
  assign dn_rem   = rem_r;
  assign dn_root  = root_r;

  // one digit of the restoring root
  always_comb begin
    rem_sh   = {up_rem[RW-1:0], up_sq[2*IDX+1 -: 2]};
    trial    = {up_root, 2'b01};
    take     = rem_sh >= trial;
    rem_nxt  = take ? rem_sh - trial : rem_sh;
    root_nxt = {up_root[RW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      sq_r   <= up_sq;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

endmodule

// ===== src/rrps_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrps_back
// Back pipeline: coverage from the distance, color choice, alpha scaling
// and the output register.
// ----------------------------------------------------------------------------
module rrps_back #(
  parameter int S = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  logic [$clog2(2047*S+1)+9:0] up_dist,
  input  logic signed [$clog2(2047*S+1)+8:0] sr8,
  input  logic [31:0] fill_color,
  input  logic [31:0] border_color,
  output logic dn_valid,
  input  logic dn_ready,
  output logic [7:0] dn_red,
  output logic [7:0] dn_green,
  output logic [7:0] dn_blue,
  output logic [7:0] dn_alpha
);
  import rrps_pkg::*;

  localparam int MULW = $clog2(2047*S+1);
  localparam int LW   = MULW + 9;
  localparam int RW   = LW + 1;
  localparam int BW   = RW + 2;
  localparam int NW   = $clog2(256*S);
  localparam int K    = NW + $clog2(S) + 1;
  localparam int MW   = K - $clog2(S) + 2;
  localparam logic [MW-1:0] RECIP = MW'(((1 << K) + S - 1) / S);
  localparam logic signed [BW-1:0] EDGE8 = BW'(S * 128);
  localparam logic signed [BW-1:0] ONE8  = BW'(S * 256);

  logic [2:0] v_r;
  logic [3:0] rdy;

  logic signed [BW-1:0] d_s, sre, num;
  logic in_aa, zero_cov;
  logic full_nxt, border_nxt;
  logic [NW-1:0] num_nxt;

  logic full_r, border1_r, border2_r;
  logic [NW-1:0] num_r;
  logic [NW+MW-1:0] prod;
  logic [8:0] cov_r;
  logic [16:0] alpha_full;
  logic [31:0] color;
  logic [7:0] red_r, green_r, blue_r, alpha_r;

  // stage advance chain
  always_comb begin
    rdy[3] = dn_ready;
    for (int i = 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[2];
  assign dn_red   = red_r;
  assign dn_green = green_r;
  assign dn_blue  = blue_r;
  assign dn_alpha = alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid;
      for (int i = 1; i < 3; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // antialias numerator and border test
  always_comb begin
    d_s        = {2'b00, up_dist};
    sre        = {{(BW-LW){sr8[LW-1]}}, sr8};
    num        = sre + EDGE8 - d_s;
    in_aa      = d_s > (sre - EDGE8);
    zero_cov   = num[BW-1] || (num == '0);
    full_nxt   = !in_aa || (num >= ONE8);
    num_nxt    = (in_aa && !full_nxt && !zero_cov) ? num[NW-1:0] : '0;
    border_nxt = d_s >= (sre - ONE8);
  end

  // divide by the supersample factor through its reciprocal
  assign prod = num_r * RECIP;

  // alpha scaling with the chosen color
  always_comb begin
    color      = border2_r ? border_color : fill_color;
    alpha_full = color[7:0] * cov_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && up_valid) begin
      full_r    <= full_nxt;
      num_r     <= num_nxt;
      border1_r <= border_nxt;
    end
    if (rdy[1] && v_r[0]) begin
      cov_r     <= full_r ? COV_ONE : {1'b0, prod[K+7:K]};
      border2_r <= border1_r;
    end
    if (rdy[2] && v_r[1]) begin
      red_r   <= color[31:24];
      green_r <= color[23:16];
      blue_r  <= color[15:8];
      alpha_r <= alpha_full[15:8];
    end
  end

endmodule

// ===== tb/tb_rounded_rect_pixel_shader_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rounded_rect_pixel_shader_unit
// Self-checking bench for the rounded rectangle pixel shader. A directed
// probe table covers reset values, the fill/border split, zero radius,
// oversized radius, zero size and out-of-surface pixels. Random phases then
// reprogram geometry and colors and stream pixels mostly around the shape.
// Every beat on out_pix is checked against a typed color or a fixed-point
// shading predictor; register readback is checked after each programming pass.
// ----------------------------------------------------------------------------
module tb_rounded_rect_pixel_shader_unit;
  import rrps_pkg::*;

  localparam int SS          = 4;   // supersample factor
  localparam int LATENCY     = 30;  // input accept to result accept at SS = 4
  localparam int RAND_PHASES = 5;
  localparam int PHASE_BEATS = 80;
  localparam int NUM_PROBES  = 22;

  // register indexes with no register behind them
  localparam logic [2:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CFG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct {
    bit          reload;
    logic [10:0] w;
    logic [10:0] h;
    logic [9:0]  r;
    logic [31:0] fill;
    logic [31:0] border;
    logic [11:0] x;
    logic [11:0] y;
    bit          typed;
    rgba_t       want;
  } probe_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rrps_in_if  in_pix ();
  rrps_out_if out_pix ();

  rounded_rect_pixel_shader_unit #(
    .SUPERSAMPLE_FACTOR(SS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pix      (in_pix),
    .out_pix     (out_pix),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow copy of the register file
  logic [10:0] cur_width;
  logic [10:0] cur_height;
  logic [9:0]  cur_radius;
  logic [31:0] cur_fill;
  logic [31:0] cur_border;

  rgba_t colors_due [$];
  rgba_t got_color;
  rgba_t due_color;
  int    mismatches;
  bit    gaps_on;

  // directed probes; config fields only matter on reload rows
  probe_t probes [0:NUM_PROBES-1] = '{
    // reset geometry, both colors zero
    '{0, 0, 0, 0, 0, 0, 0, 0, 1, 32'h0000_0000},
    '{0, 0, 0, 0, 0, 0, 4095, 4095, 1, 32'h0000_0000},
    // default-sized shape with colors: interior, far outside, corners, edges
    '{1, 64, 32, 8, 32'h1122_3380, 32'hAABB_CCFF, 128, 64, 1, 32'h1122_3380},
    '{0, 0, 0, 0, 0, 0, 4095, 4095, 1, 32'hAABB_CC00},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 31, 31, 0, 0},
    '{0, 0, 0, 0, 0, 0, 255, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 64, 0, 0},
    '{0, 0, 0, 0, 0, 0, 2, 64, 0, 0},
    '{0, 0, 0, 0, 0, 0, 128, 127, 0, 0},
    // zero radius: border color at half coverage
    '{1, 64, 32, 0, 32'h1122_3380, 32'hAABB_CCFF, 5, 5, 1, 32'hAABB_CC7F},
    '{0, 0, 0, 0, 0, 0, 0, 0, 1, 32'hAABB_CC7F},
    '{0, 0, 0, 0, 0, 0, 4095, 4095, 0, 0},
    // radius beyond half the size
    '{1, 4, 4, 512, 32'hFFFF_FFFF, 32'h0000_0000, 8, 8, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // zero width and height
    '{1, 0, 0, 3, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 20, 7, 0, 0},
    // all register bits high
    '{1, 2047, 2047, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4095, 4095, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 2048, 2048, 0, 0},
    // largest nominal size
    '{1, 1024, 1024, 512, 32'h0000_0000, 32'hFFFF_FFFF, 4095, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 1, 4094, 0, 0}
  };

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // watchdog
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // shadow register update, unknown indexes are dropped
  function automatic void store_register(logic [2:0] idx, logic [31:0] val);
    case (idx)
      CFG_RECT_WIDTH:    cur_width  = val[10:0];
      CFG_RECT_HEIGHT:   cur_height = val[10:0];
      CFG_CORNER_RADIUS: cur_radius = val[9:0];
      CFG_FILL_COLOR:    cur_fill   = val;
      CFG_BORDER_COLOR:  cur_border = val;
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] register_value(logic [2:0] idx);
    case (idx)
      CFG_RECT_WIDTH:    return {21'd0, cur_width};
      CFG_RECT_HEIGHT:   return {21'd0, cur_height};
      CFG_CORNER_RADIUS: return {22'd0, cur_radius};
      CFG_FILL_COLOR:    return cur_fill;
      CFG_BORDER_COLOR:  return cur_border;
      default:           return 32'd0;
    endcase
  endfunction

  // pull a Q.8 coordinate onto the corner-centre span, low side first
  function automatic longint corner_centre(longint p, longint r, longint full);
    if (p < r) return r;
    if (p > full - r) return full - r;
    return p;
  endfunction

  // expected color of one supersampled pixel under the shadow registers
  function automatic rgba_t shade_pixel(logic [11:0] x, logic [11:0] y);
    longint          sw8, sh8, sr8, px8, py8, dx, dy, d_len, num, cov, a;
    longint unsigned sumsq, root, trial;
    logic [31:0]     color;
    rgba_t           px;
    sw8 = longint'(cur_width) * SS * 256;
    sh8 = longint'(cur_height) * SS * 256;
    sr8 = longint'(cur_radius) * SS * 256;
    px8 = longint'(x) * 256 + 128;
    py8 = longint'(y) * 256 + 128;
    dx  = px8 - corner_centre(px8, sr8, sw8);
    dy  = py8 - corner_centre(py8, sr8, sh8);
    sumsq = longint'(dx * dx) + longint'(dy * dy);
    // truncated root, one bit at a time from the top
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sumsq) root = trial;
    end
    d_len = longint'(root);
    // antialias coverage over an edge one output pixel wide
    cov = 256;
    if (d_len > sr8 - SS * 128) begin
      num = sr8 + SS * 128 - d_len;
      if (num <= 0) cov = 0;
      else cov = (num / SS > 256) ? 256 : num / SS;
    end
    color = (d_len >= sr8 - SS * 256) ? cur_border : cur_fill;
    a = (longint'(color[7:0]) * cov) >>> 8;
    px.red   = color[31:24];
    px.green = color[23:16];
    px.blue  = color[15:8];
    px.alpha = a[7:0];
    return px;
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t error: %s", $realtime, msg);
  endfunction

  // mostly short idles, now and then a long one
  function automatic int pause_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // coordinates mostly around the shape, some anywhere on the surface
  function automatic logic [11:0] pick_coord(logic [10:0] extent);
    int hi;
    hi = int'(extent) * SS + 8;
    if (hi > 4095) hi = 4095;
    if ($urandom_range(0, 9) < 7) return 12'($urandom_range(0, hi));
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [10:0] pick_size();
    case ($urandom_range(0, 11))
      0:       return 11'd0;
      1:       return 11'd1;
      2:       return 11'd1024;
      3:       return 11'd2047;
      default: return 11'($urandom_range(1, 40));
    endcase
  endfunction

  // apb write, leaves the bus selected for a back-to-back transfer
  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    store_register(idx, val);
  endtask

  // apb read of every register, compared with the shadow copy
  task automatic check_registers();
    logic [31:0] rd;
    for (int i = CFG_RECT_WIDTH; i <= CFG_BORDER_COLOR; i++) begin
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
      cfg_paddr   <= {3'(i), 2'b00};
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
      rd = cfg_prdata;
      if (rd !== register_value(3'(i)))
        flag_error($sformatf("register %0d read %h, want %h", i, rd,
                             register_value(3'(i))));
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // stop sending and wait for every pixel in flight
  task automatic drain_results();
    in_pix.valid <= 1'b0;
    while (colors_due.size() != 0) @(posedge clk);
  endtask

  task automatic load_geometry(logic [10:0] w, logic [10:0] h, logic [9:0] r,
                               logic [31:0] fill, logic [31:0] border);
    drain_results();
    cfg_write(CFG_RECT_WIDTH, {11'($urandom_range(0, 2047)), 21'd0} | 32'(w));
    cfg_write(CFG_RECT_HEIGHT, 32'(h));
    cfg_write(CFG_CORNER_RADIUS, 32'(r));
    cfg_write(CFG_FILL_COLOR, fill);
    cfg_write(CFG_BORDER_COLOR, border);
    // a write to an unmapped index must leave the registers alone
    cfg_write(3'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), $urandom);
    check_registers();
  endtask

  task automatic random_geometry();
    logic [10:0] w, h;
    int          half;
    w = pick_size();
    h = pick_size();
    half = ((w < h) ? int'(w) : int'(h)) / 2 + 1;
    if (half > 1023) half = 1023;
    case ($urandom_range(0, 9))
      0:       load_geometry(w, h, 10'd0, $urandom, $urandom);
      1:       load_geometry(w, h, 10'($urandom_range(0, 1023)), $urandom, $urandom);
      default: load_geometry(w, h, 10'($urandom_range(0, half)), $urandom, $urandom);
    endcase
  endtask

  // one pixel beat, the expected color is queued once it is taken
  task automatic send_pixel(logic [11:0] x, logic [11:0] y, rgba_t want);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      in_pix.valid <= 1'b0;
      repeat (pause_len()) @(posedge clk);
    end
    in_pix.valid   <= 1'b1;
    in_pix.pixel_x <= x;
    in_pix.pixel_y <= y;
    do @(posedge clk); while (!in_pix.ready);
    colors_due.push_back(want);
  endtask

  // result side back-pressure
  initial begin
    out_pix.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_pix.ready <= 1'b0;
        repeat (pause_len()) @(posedge clk);
        out_pix.ready <= 1'b1;
      end else begin
        out_pix.ready <= 1'b1;
      end
    end
  end

  // compare each color beat with the oldest expected color
  always @(posedge clk) begin
    if (rst_n && out_pix.valid && out_pix.ready) begin
      got_color = '{out_pix.red, out_pix.green, out_pix.blue, out_pix.alpha};
      if (colors_due.size() == 0) begin
        flag_error($sformatf("color beat %h with nothing pending", got_color));
      end else begin
        due_color = colors_due.pop_front();
        if (got_color.red !== due_color.red || got_color.green !== due_color.green ||
            got_color.blue !== due_color.blue || got_color.alpha !== due_color.alpha)
          flag_error($sformatf("rgba got %h_%h_%h_%h, want %h_%h_%h_%h",
                               got_color.red, got_color.green, got_color.blue,
                               got_color.alpha, due_color.red, due_color.green,
                               due_color.blue, due_color.alpha));
      end
    end
  end

  // main sequence
  initial begin
    logic [11:0] x, y;
    mismatches = 0;
    gaps_on    = 1'b1;
    cur_width  = RST_RECT_WIDTH;
    cur_height = RST_RECT_HEIGHT;
    cur_radius = RST_CORNER_RADIUS;
    cur_fill   = RST_FILL_COLOR;
    cur_border = RST_BORDER_COLOR;
    rst_n          <= 1'b0;
    in_pix.valid   <= 1'b0;
    in_pix.pixel_x <= '0;
    in_pix.pixel_y <= '0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_registers();

    // directed probes
    foreach (probes[i]) begin
      if (probes[i].reload)
        load_geometry(probes[i].w, probes[i].h, probes[i].r,
                      probes[i].fill, probes[i].border);
      send_pixel(probes[i].x, probes[i].y,
                 probes[i].typed ? probes[i].want :
                                   shade_pixel(probes[i].x, probes[i].y));
    end

    // random phases, idles on every other one
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_geometry();
      gaps_on = (ph % 2 == 0);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // hold off mid-phase until the pipe is empty
        if (ph == 2 && n == PHASE_BEATS / 2) drain_results();
        x = pick_coord(cur_width);
        y = pick_coord(cur_height);
        send_pixel(x, y, shade_pixel(x, y));
      end
    end

    drain_results();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatches == 0 && colors_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rrps_pkg.sv
src/rrps_in_if.sv
src/rrps_out_if.sv
src/rrps_front.sv
src/rrps_sqrt_cell.sv
src/rrps_back.sv
src/rounded_rect_pixel_shader_unit.sv
tb/tb_rounded_rect_pixel_shader_unit.sv
